// File: rtl/lmc_pkg.sv
`timescale 1ns / 1ps

package lmc_pkg;

    localparam int MEM_DEPTH   = 1024;                 // power of two, at most 1024
    localparam int ADDR_W      = $clog2(MEM_DEPTH);
    localparam int DATA_W      = 32;
    localparam int OPC_W       = 4;
    localparam int WORD_W      = OPC_W + DATA_W;
    localparam int KIND_W      = 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // command codes as they arrive on the port
    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_STEP    = 2'd1,
        CMD_RESTART = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    // opcodes
    localparam logic [OPC_W-1:0] OP_HLT = 4'd0;
    localparam logic [OPC_W-1:0] OP_ADD = 4'd1;
    localparam logic [OPC_W-1:0] OP_SUB = 4'd2;
    localparam logic [OPC_W-1:0] OP_STA = 4'd3;
    localparam logic [OPC_W-1:0] OP_LDA = 4'd5;
    localparam logic [OPC_W-1:0] OP_BRA = 4'd6;
    localparam logic [OPC_W-1:0] OP_BRP = 4'd7;
    localparam logic [OPC_W-1:0] OP_BRZ = 4'd8;
    localparam logic [OPC_W-1:0] OP_IO  = 4'd9;

    // I/O operand codes
    localparam logic [DATA_W-1:0] IO_INP = 32'd1;
    localparam logic [DATA_W-1:0] IO_OUT = 32'd2;
    localparam logic [DATA_W-1:0] IO_OTC = 32'd22;

    // output kinds
    localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NUM  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CHAR = 2'd2;

    typedef struct packed {
        cmd_t              cmd;
        logic [ADDR_W-1:0] load_addr;
        logic [OPC_W-1:0]  load_opc;
        logic [DATA_W-1:0] load_opnd;
        logic [DATA_W-1:0] in_val;
    } item_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [DATA_W-1:0] value;
        logic              taken;
        logic              halted;
        logic [ADDR_W-1:0] pc;
        logic [DATA_W-1:0] acc;
    } res_t;

endpackage

// File: rtl/lmc_accumulator_cpu_step.sv
`timescale 1ns / 1ps

// Accumulator CPU in the Little Man Computer style with a 1024-word program
// store (4-bit opcode, 32-bit operand per word). Each input word carries one
// command (load a memory word, execute one instruction, restart at address 0)
// and produces exactly one result word with any output, the input-taken flag,
// and the machine state afterwards. Loads, restarts, unused commands and steps
// while halted are answered straight from the idle state; an executed step
// runs fetch from the program store, operand read and execute/writeback in
// turn, set by the single registered read port of the store. A two-entry
// queue sits between the command front end and the execution back end, and
// the result register lets the next command be taken while a result waits.
// The store has no reset; executing or reading a word that was never loaded
// or stored gives an undefined result.

module lmc_accumulator_cpu_step (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         command,
    input  logic [9:0]         load_address,
    input  logic [3:0]         load_opcode,
    input  logic signed [31:0] load_operand,
    input  logic signed [31:0] input_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         output_kind,
    output logic signed [31:0] output_value,
    output logic               input_taken,
    output logic               is_halted,
    output logic [9:0]         next_pc,
    output logic signed [31:0] acc_value
);

    // front end -> queue
    logic           q_push;
    logic           q_full;
    lmc_pkg::item_t push_item;

    // queue -> back end
    logic           q_pop;
    logic           q_valid;
    lmc_pkg::item_t head_item;

    lmc_pkg::res_t  res;

    lmc_front u_front (
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .load_address (load_address),
        .load_opcode  (load_opcode),
        .load_operand (load_operand),
        .input_value  (input_value),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_item       (push_item)
    );

    lmc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (push_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_item  (head_item)
    );

    // executes commands in order; owns the program store and the result word
    lmc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (head_item),
        .q_pop     (q_pop),
        .res_valid (out_valid),
        .res_ready (out_ready),
        .res       (res)
    );

    assign output_kind  = res.kind;
    assign output_value = res.value;
    assign input_taken  = res.taken;
    assign is_halted    = res.halted;
    assign next_pc      = 10'(res.pc);
    assign acc_value    = res.acc;

endmodule

// File: rtl/lmc_front.sv
`timescale 1ns / 1ps

module lmc_front (
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   command,
    input  logic [9:0]                   load_address,
    input  logic [3:0]                   load_opcode,
    input  logic signed [31:0]           load_operand,
    input  logic signed [31:0]           input_value,
    input  logic                         q_full,
    output logic                         q_push,
    output lmc_pkg::item_t               q_item
);

    lmc_pkg::cmd_t cmd_c;

    always_comb
    begin
        case (command)
            lmc_pkg::CMD_LOAD:    cmd_c = lmc_pkg::CMD_LOAD;
            lmc_pkg::CMD_STEP:    cmd_c = lmc_pkg::CMD_STEP;
            lmc_pkg::CMD_RESTART: cmd_c = lmc_pkg::CMD_RESTART;
            default:              cmd_c = lmc_pkg::CMD_NONE;
        endcase
    end

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        q_item.cmd       = cmd_c;
        q_item.load_addr = load_address[lmc_pkg::ADDR_W-1:0];
        q_item.load_opc  = load_opcode;
        q_item.load_opnd = load_operand;
        q_item.in_val    = input_value;
    end

endmodule

// File: rtl/lmc_queue.sv
`timescale 1ns / 1ps

module lmc_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  lmc_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output lmc_pkg::item_t head_item
);

    lmc_pkg::item_t                    slots [lmc_pkg::QUEUE_DEPTH];
    logic [lmc_pkg::QPTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [lmc_pkg::QPTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [lmc_pkg::QCNT_W-1:0]        count_reg, count_next;
    logic                              do_push, do_pop;

    assign full       = (count_reg == lmc_pkg::QCNT_W'(lmc_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = slots[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == lmc_pkg::QPTR_W'(lmc_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == lmc_pkg::QPTR_W'(lmc_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: rtl/lmc_back.sv
`timescale 1ns / 1ps

module lmc_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  lmc_pkg::item_t q_item,
    output logic           q_pop,
    output logic           res_valid,
    input  logic           res_ready,
    output lmc_pkg::res_t  res
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_EXEC
    } state_t;

    state_t                         state_reg, state_next;
    logic [lmc_pkg::ADDR_W-1:0]     pc_reg, pc_next;
    logic [lmc_pkg::DATA_W-1:0]     acc_reg, acc_next;
    logic                           halt_reg, halt_next;
    logic [lmc_pkg::WORD_W-1:0]     ir_reg, ir_next;
    logic [lmc_pkg::DATA_W-1:0]     cur_in_reg, cur_in_next;
    logic                           out_valid_reg, out_valid_next;
    lmc_pkg::res_t                  res_reg, res_next;

    // program store, one write and one registered read port
    logic [lmc_pkg::WORD_W-1:0]     prog_mem [lmc_pkg::MEM_DEPTH];
    logic [lmc_pkg::WORD_W-1:0]     rd_data_reg;
    logic                           mem_we, mem_re;
    logic [lmc_pkg::ADDR_W-1:0]     mem_waddr, mem_raddr;
    logic [lmc_pkg::WORD_W-1:0]     mem_wdata;

    logic                           out_free, emit, jump, stop, taken;
    logic [lmc_pkg::KIND_W-1:0]     kind;
    logic [lmc_pkg::DATA_W-1:0]     value;
    logic [lmc_pkg::OPC_W-1:0]      ir_op, fetch_op;
    logic [lmc_pkg::DATA_W-1:0]     ir_opnd, mem_opnd;
    logic [lmc_pkg::ADDR_W-1:0]     ir_addr;

    assign out_free  = !out_valid_reg || res_ready;
    assign res_valid = out_valid_reg;
    assign res       = res_reg;

    assign ir_op    = ir_reg[lmc_pkg::WORD_W-1 -: lmc_pkg::OPC_W];
    assign ir_opnd  = ir_reg[lmc_pkg::DATA_W-1:0];
    assign ir_addr  = ir_reg[lmc_pkg::ADDR_W-1:0];
    assign mem_opnd = rd_data_reg[lmc_pkg::DATA_W-1:0];
    assign fetch_op = rd_data_reg[lmc_pkg::WORD_W-1 -: lmc_pkg::OPC_W];

    always_comb
    begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        acc_next       = acc_reg;
        halt_next      = halt_reg;
        ir_next        = ir_reg;
        cur_in_next    = cur_in_reg;
        out_valid_next = out_valid_reg && !res_ready;
        res_next       = res_reg;
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_waddr      = '0;
        mem_raddr      = '0;
        mem_wdata      = '0;
        emit           = 1'b0;
        jump           = 1'b0;
        stop           = 1'b0;
        taken          = 1'b0;
        kind           = lmc_pkg::KIND_NONE;
        value          = '0;

        case (state_reg)
            S_IDLE:
            begin
                // a running step only starts its fetch; everything else answers now
                if (q_valid && ((q_item.cmd == lmc_pkg::CMD_STEP && !halt_reg) || out_free))
                begin
                    q_pop       = 1'b1;
                    cur_in_next = q_item.in_val;
                    case (q_item.cmd)
                        lmc_pkg::CMD_LOAD:
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = q_item.load_addr;
                            mem_wdata = {q_item.load_opc, q_item.load_opnd};
                            emit      = 1'b1;
                        end
                        lmc_pkg::CMD_RESTART:
                        begin
                            pc_next   = '0;
                            halt_next = 1'b0;
                            emit      = 1'b1;
                        end
                        lmc_pkg::CMD_STEP:
                        begin
                            if (halt_reg)
                            begin
                                emit = 1'b1;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = pc_reg;
                                state_next = S_FETCH;
                            end
                        end
                        default:
                        begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end

            S_FETCH:
            begin
                ir_next = rd_data_reg;
                if (fetch_op inside {lmc_pkg::OP_ADD, lmc_pkg::OP_SUB, lmc_pkg::OP_LDA})
                begin
                    mem_re    = 1'b1;
                    mem_raddr = rd_data_reg[lmc_pkg::ADDR_W-1:0];
                end
                state_next = S_EXEC;
            end

            S_EXEC:
            begin
                if (out_free)
                begin
                    case (ir_op)
                        lmc_pkg::OP_HLT: stop     = (ir_opnd == '0);
                        lmc_pkg::OP_ADD: acc_next = acc_reg + mem_opnd;
                        lmc_pkg::OP_SUB: acc_next = acc_reg - mem_opnd;
                        lmc_pkg::OP_STA:
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = ir_addr;
                            mem_wdata = {lmc_pkg::OP_HLT, acc_reg};
                        end
                        lmc_pkg::OP_LDA: acc_next = mem_opnd;
                        lmc_pkg::OP_BRA: jump     = 1'b1;
                        lmc_pkg::OP_BRP: jump     = !acc_reg[lmc_pkg::DATA_W-1];
                        lmc_pkg::OP_BRZ: jump     = (acc_reg == '0);
                        lmc_pkg::OP_IO:
                        begin
                            if (ir_opnd == lmc_pkg::IO_INP)
                            begin
                                acc_next = cur_in_reg;
                                taken    = 1'b1;
                            end
                            else if (ir_opnd == lmc_pkg::IO_OUT)
                            begin
                                kind  = lmc_pkg::KIND_NUM;
                                value = acc_reg;
                            end
                            else if (ir_opnd == lmc_pkg::IO_OTC)
                            begin
                                kind  = lmc_pkg::KIND_CHAR;
                                value = lmc_pkg::DATA_W'(acc_reg[7:0]);
                            end
                        end
                        default: ;
                    endcase

                    // halt keeps pc on the halt word; falling off the end halts and wraps pc to 0
                    if (stop)
                    begin
                        halt_next = 1'b1;
                    end
                    else if (jump)
                    begin
                        pc_next = ir_addr;
                    end
                    else if (pc_reg == lmc_pkg::ADDR_W'(lmc_pkg::MEM_DEPTH - 1))
                    begin
                        halt_next = 1'b1;
                        pc_next   = '0;
                    end
                    else
                    begin
                        pc_next = pc_reg + 1'b1;
                    end

                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (emit)
        begin
            out_valid_next  = 1'b1;
            res_next.kind   = kind;
            res_next.value  = value;
            res_next.taken  = taken;
            res_next.halted = halt_next;
            res_next.pc     = pc_next;
            res_next.acc    = acc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pc_reg        <= '0;
            acc_reg       <= '0;
            halt_reg      <= 1'b0;
            ir_reg        <= '0;
            cur_in_reg    <= '0;
            out_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            acc_reg       <= acc_next;
            halt_reg      <= halt_next;
            ir_reg        <= ir_next;
            cur_in_reg    <= cur_in_next;
            out_valid_reg <= out_valid_next;
            res_reg       <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            prog_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= prog_mem[mem_raddr];
        end
    end

endmodule

// File: tb/sv/lmc_accumulator_cpu_step_checker.sv
`timescale 1ns / 1ps

module lmc_accumulator_cpu_step_checker
    import lmc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [1:0]         command,
    input  logic [9:0]         load_address,
    input  logic [3:0]         load_opcode,
    input  logic signed [31:0] load_operand,
    input  logic signed [31:0] input_value,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [1:0]         output_kind,
    input  logic signed [31:0] output_value,
    input  logic               input_taken,
    input  logic               is_halted,
    input  logic [9:0]         next_pc,
    input  logic signed [31:0] acc_value,
    output int                 fails,
    output int                 pending,
    output int                 compared
);

    // shadow machine
    logic [OPC_W-1:0]  mem_opc  [0:MEM_DEPTH-1];
    logic [DATA_W-1:0] mem_opnd [0:MEM_DEPTH-1];
    logic [DATA_W-1:0] acc;
    logic [ADDR_W-1:0] pc;
    logic              halted;

    res_t reports [$];

    initial
    begin
        fails    = 0;
        compared = 0;
        pending  = 0;
    end

    // applies one command word to the shadow machine, returns the report it gives
    function automatic res_t run_command(cmd_t c, logic [ADDR_W-1:0] addr,
                                         logic [OPC_W-1:0] opc, logic [DATA_W-1:0] opnd,
                                         logic [DATA_W-1:0] inval);
        res_t              r;
        logic [ADDR_W-1:0] cur;
        logic [ADDR_W-1:0] tgt;
        logic [OPC_W-1:0]  op;
        logic [DATA_W-1:0] w;
        logic              jump;
        logic              stop;
        r = '0;
        case (c)
            CMD_LOAD:
            begin
                mem_opc[addr]  = opc;
                mem_opnd[addr] = opnd;
            end
            CMD_RESTART:
            begin
                pc     = '0;
                halted = 1'b0;
            end
            CMD_STEP:
            begin
                if (!halted)
                begin
                    cur  = pc;
                    op   = mem_opc[cur];
                    w    = mem_opnd[cur];
                    tgt  = w[ADDR_W-1:0];
                    jump = 1'b0;
                    stop = 1'b0;
                    case (op)
                        OP_HLT: stop = (w == '0);
                        OP_ADD: acc = acc + mem_opnd[tgt];
                        OP_SUB: acc = acc - mem_opnd[tgt];
                        OP_STA:
                        begin
                            mem_opc[tgt]  = OP_HLT;   // stored words are data words
                            mem_opnd[tgt] = acc;
                        end
                        OP_LDA: acc = mem_opnd[tgt];
                        OP_BRA: jump = 1'b1;
                        OP_BRP: jump = !acc[DATA_W-1];
                        OP_BRZ: jump = (acc == '0);
                        OP_IO:
                        begin
                            if (w == IO_INP)
                            begin
                                acc     = inval;
                                r.taken = 1'b1;
                            end
                            else if (w == IO_OUT)
                            begin
                                r.kind  = KIND_NUM;
                                r.value = acc;
                            end
                            else if (w == IO_OTC)
                            begin
                                r.kind  = KIND_CHAR;
                                r.value = {24'b0, acc[7:0]};
                            end
                        end
                        default: ;
                    endcase
                    if (stop)
                        halted = 1'b1;
                    else if (jump)
                        pc = tgt;
                    else if (cur == ADDR_W'(MEM_DEPTH - 1))
                    begin
                        halted = 1'b1;
                        pc     = '0;
                    end
                    else
                        pc = cur + 1'b1;
                end
            end
            default: ;
        endcase
        r.halted = halted;
        r.pc     = pc;
        r.acc    = acc;
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            fails++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        if (!rst_n)
        begin
            acc    = '0;
            pc     = '0;
            halted = 1'b0;
            reports.delete();
            pending = 0;
        end
        else
        begin
            // result side first: a result on this edge belongs to an older word
            if (out_valid && out_ready)
            begin
                compared++;
                if (reports.size() == 0)
                begin
                    $display("%0t: result word with none expected, expected nothing actual %0h",
                             $time, {output_kind, output_value, input_taken, is_halted,
                                     next_pc, acc_value});
                    fails++;
                end
                else
                begin
                    want = reports.pop_front();
                    check_field("output_kind",  32'(want.kind),   32'(output_kind));
                    check_field("output_value", want.value,       output_value);
                    check_field("input_taken",  32'(want.taken),  32'(input_taken));
                    check_field("is_halted",    32'(want.halted), 32'(is_halted));
                    check_field("next_pc",      32'(want.pc),     32'(next_pc));
                    check_field("acc_value",    want.acc,         acc_value);
                end
            end
            if (in_valid && in_ready)
                reports.push_back(run_command(cmd_t'(command), load_address, load_opcode,
                                              load_operand, input_value));
            pending = reports.size();
        end
    end

endmodule

// File: tb/sv/lmc_accumulator_cpu_step_tb.sv
`timescale 1ns / 1ps

module lmc_accumulator_cpu_step_tb;
    import lmc_pkg::*;

    localparam int RANDOM_WORDS     = 760;
    localparam int DRAIN_EVERY      = 400;    // sender waits for an empty pipe this often
    localparam int LONG_HOLD_AT     = 1400;   // result count at which the sink stops
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES      = 20;
    localparam int CYCLE_LIMIT      = 500000;
    localparam int DATA_BASE        = 960;    // scratch words used by ADD/SUB/LDA/STA
    localparam logic [OPC_W-1:0] OP_NOP = 4'd4;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         command;
    logic [9:0]         load_address;
    logic [3:0]         load_opcode;
    logic signed [31:0] load_operand;
    logic signed [31:0] input_value;
    logic               out_valid;
    logic               out_ready;
    logic [1:0]         output_kind;
    logic signed [31:0] output_value;
    logic               input_taken;
    logic               is_halted;
    logic [9:0]         next_pc;
    logic signed [31:0] acc_value;

    int  fails;
    int  pending;
    int  compared;
    int  cycles = 0;
    int  words_sent = 0;      // command words accepted, unused command code excluded
    int  random_start = 0;
    bit  tx_idle = 1'b1;      // sender draws gaps when set, streams back to back otherwise

    lmc_accumulator_cpu_step uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .load_address (load_address),
        .load_opcode  (load_opcode),
        .load_operand (load_operand),
        .input_value  (input_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .output_kind  (output_kind),
        .output_value (output_value),
        .input_taken  (input_taken),
        .is_halted    (is_halted),
        .next_pc      (next_pc),
        .acc_value    (acc_value)
    );

    // watches both channels, predicts every result and compares
    lmc_accumulator_cpu_step_checker chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .load_address (load_address),
        .load_opcode  (load_opcode),
        .load_operand (load_operand),
        .input_value  (input_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .output_kind  (output_kind),
        .output_value (output_value),
        .input_taken  (input_taken),
        .is_halted    (is_halted),
        .next_pc      (next_pc),
        .acc_value    (acc_value),
        .fails        (fails),
        .pending      (pending),
        .compared     (compared)
    );

    always #2 clk = ~clk;

    // hard stop if the pipe hangs
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still expected", cycles, pending);
            $display("lmc_accumulator_cpu_step: mismatch");
            $finish;
        end
    end

    // data values biased toward the corners of the 32-bit range
    function automatic logic [31:0] rand_data();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            4:       return 32'($urandom_range(0, 255));
            5:       return -32'($urandom_range(0, 255));
            default: return $urandom;
        endcase
    endfunction

    // operand naming address a; upper bits are garbage half the time
    function automatic logic [31:0] with_junk(int a);
        logic [31:0] w;
        w = $urandom_range(0, 1) ? $urandom : 32'h0;
        w[ADDR_W-1:0] = a[ADDR_W-1:0];
        return w;
    endfunction

    // offer one word and hold it until accepted; called at a rising edge
    task automatic send_word(cmd_t c, logic [ADDR_W-1:0] a, logic [OPC_W-1:0] o,
                             logic [DATA_W-1:0] d, logic [DATA_W-1:0] v);
        int gap;
        gap = tx_idle ? $urandom_range(0, 8) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        command      <= c;
        load_address <= a;
        load_opcode  <= o;
        load_operand <= d;
        input_value  <= v;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (c != CMD_NONE)
            words_sent++;
    endtask

    task automatic load_word(int a, logic [OPC_W-1:0] o, logic [DATA_W-1:0] d);
        send_word(CMD_LOAD, ADDR_W'(a), o, d, $urandom);
    endtask

    task automatic step_cpu(logic [DATA_W-1:0] v);
        send_word(CMD_STEP, ADDR_W'($urandom), OPC_W'($urandom_range(0, 9)), $urandom, v);
    endtask

    task automatic restart_cpu();
        send_word(CMD_RESTART, ADDR_W'($urandom), OPC_W'($urandom_range(0, 9)), $urandom,
                  $urandom);
    endtask

    // stop offering until every predicted result has come back
    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        @(posedge clk);
    endtask

    // short program somewhere in memory, then usually a restart, and a run of steps
    task automatic run_program();
        int          len;
        int          base;
        int          pick;
        logic [3:0]  op;
        logic [31:0] arg;
        len  = $urandom_range(3, 12);
        pick = $urandom_range(0, 99);
        if (pick < 65)
            base = 0;
        else if (pick < 85)
            base = MEM_DEPTH - len;              // ends on the last word: run-off case
        else
            base = $urandom_range(100, 900);
        if (base != 0)
            load_word(0, OP_BRA, with_junk(base));
        for (int i = 0; i < len; i++)
        begin
            case ($urandom_range(0, 19))
                0:        begin op = OP_HLT; arg = 32'h0; end
                1:        begin op = OP_HLT; arg = rand_data() | 32'h1; end
                2, 3:     begin op = OP_ADD; arg = with_junk(DATA_BASE + $urandom_range(0, 15)); end
                4:        begin op = OP_SUB; arg = with_junk(DATA_BASE + $urandom_range(0, 15)); end
                5, 6:     begin op = OP_STA; arg = with_junk(DATA_BASE + $urandom_range(0, 15)); end
                7, 8:     begin op = OP_LDA; arg = with_junk(DATA_BASE + $urandom_range(0, 15)); end
                9:        begin op = OP_BRA; arg = with_junk(base + $urandom_range(0, len - 1)); end
                10, 11:   begin op = OP_BRP; arg = with_junk(base + $urandom_range(0, len - 1)); end
                12, 13:   begin op = OP_BRZ; arg = with_junk(base + $urandom_range(0, len - 1)); end
                14, 15:   begin op = OP_IO;  arg = IO_INP; end
                16:       begin op = OP_IO;  arg = IO_OUT; end
                17:       begin op = OP_IO;  arg = IO_OTC; end
                18:       begin op = OP_IO;  arg = rand_data(); end
                default:  begin op = OP_NOP; arg = rand_data(); end
            endcase
            load_word(base + i, op, arg);
        end
        if ($urandom_range(0, 3) != 0)
            restart_cpu();
        repeat ($urandom_range(4, 40)) step_cpu(rand_data());
    endtask

    // unstructured word, occasionally the unused command code
    task automatic noise_word();
        cmd_t c;
        c = ($urandom_range(0, 15) == 0) ? CMD_NONE : cmd_t'($urandom_range(0, 2));
        send_word(c, ADDR_W'($urandom), OPC_W'($urandom_range(0, 9)), rand_data(), rand_data());
    endtask

    // result sink: random back-pressure, streaming stretches, one long hold-off
    initial
    begin
        int gap;
        int taken;
        bit rx_idle;
        out_ready <= 1'b0;
        taken   = 0;
        rx_idle = 1'b1;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (taken % 128 == 0)
                rx_idle = $urandom_range(0, 3) != 0;
            gap = rx_idle ? $urandom_range(0, 8) : 0;
            if (taken == LONG_HOLD_AT)
            begin
                // the sender keeps offering, so the queue fills and in_ready drops
                out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
            end
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            taken++;
        end
    end

    initial
    begin
        int next_drain;
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        command      <= CMD_LOAD;
        load_address <= '0;
        load_opcode  <= '0;
        load_operand <= '0;
        input_value  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill the whole store first so no step ever reads an unwritten word;
        // loads leave pc, acc and halt at their reset values
        for (int a = 0; a < MEM_DEPTH; a++)
            load_word(a, OPC_W'($urandom_range(0, 9)), rand_data());
        drain();

        // directed: every I/O code, extreme values, both failing branches,
        // run-off at the last word, step while halted, unused command, halt word
        tx_idle = 1'b0;
        load_word(1001, OP_HLT, 32'h8000_0000);
        load_word(0,    OP_IO,  IO_INP);
        load_word(1,    OP_IO,  IO_OUT);
        load_word(2,    OP_IO,  IO_OTC);
        load_word(3,    OP_ADD, 32'd1001);
        load_word(4,    OP_BRP, 32'd1022);
        load_word(5,    OP_BRZ, 32'd0);
        load_word(6,    OP_STA, 32'd1000);
        load_word(7,    OP_LDA, 32'hffff_fc00 | 32'd1001);   // upper bits ignored
        load_word(8,    OP_BRA, 32'd1022);
        load_word(1022, OP_NOP, 32'h7fff_ffff);
        load_word(1023, OP_IO,  32'd5);                      // I/O code with no meaning
        restart_cpu();
        step_cpu(32'h7fff_ffff);     // INP of the largest value
        step_cpu($urandom);          // OUT
        step_cpu($urandom);          // OTC, low byte 0xff
        step_cpu($urandom);          // ADD min: acc becomes -1
        step_cpu($urandom);          // BRP not taken on negative
        step_cpu($urandom);          // BRZ not taken
        step_cpu($urandom);          // STA
        step_cpu($urandom);          // LDA min
        step_cpu($urandom);          // BRA to 1022
        step_cpu($urandom);          // no-op at 1022
        step_cpu($urandom);          // last word: halt, pc wraps to 0
        step_cpu($urandom);          // halted: no change
        send_word(CMD_NONE, ADDR_W'($urandom), OPC_W'($urandom_range(0, 9)), $urandom,
                  $urandom);
        restart_cpu();
        load_word(0, OP_HLT, 32'h0);
        step_cpu(32'h8000_0000);     // halt word, pc stays
        step_cpu(32'h8000_0000);
        restart_cpu();
        drain();

        // random programs with some noise in between
        random_start = words_sent;
        next_drain   = DRAIN_EVERY;
        while (words_sent - random_start < RANDOM_WORDS)
        begin
            tx_idle = $urandom_range(0, 3) != 0;
            if ($urandom_range(0, 9) < 8)
                run_program();
            else
                repeat ($urandom_range(1, 6)) noise_word();
            if (words_sent - random_start >= next_drain)
            begin
                drain();
                next_drain += DRAIN_EVERY;
            end
        end
        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d command words: full store fill, directed corners, %0d random",
                 words_sent, words_sent - random_start);
        $display("%0d result words compared, %0d failed checks", compared, fails);
        if (fails == 0)
            $display("lmc_accumulator_cpu_step: match");
        else
            $display("lmc_accumulator_cpu_step: mismatch");
        $finish;
    end

endmodule
